>>> rtl/ccs_pkg.sv
package ccs_pkg;

  typedef enum logic [3:0] {
    ST_CODE    = 4'd0,
    ST_SLASH   = 4'd1,
    ST_BLOCK   = 4'd2,
    ST_STAR    = 4'd3,
    ST_LINE    = 4'd4,
    ST_CHR     = 4'd5,
    ST_CHR_ESC = 4'd6,
    ST_STR     = 4'd7,
    ST_STR_ESC = 4'd8,
    ST_LINE_BS = 4'd9
  } parse_state_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_ONE  = 2'd1;
  localparam logic [1:0] EMIT_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]  emit_count;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [31:0] comments_removed;
  } out_t;

endpackage

>>> rtl/c_comment_stripper.sv
// The result for each accepted input transaction is registered.
// Throughput: one byte per cycle; the parser state and counter update in the
// accepting cycle, and byte_ready stays high while the result register is empty or taken.
// Reset (rst, synchronous, active high): parser to plain code, counter to zero,
// result register empty. A byte marked end_of_text also resets the parser and counter, not the result register.
module c_comment_stripper (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  ccs_pkg::in_t   byte_data,
  output logic           res_valid,
  input  logic           res_ready,
  output ccs_pkg::out_t  res_data
);
  import ccs_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  logic [31:0]  total;
  logic [31:0]  total_next;
  logic         accept;
  logic         count_inc;
  logic [1:0]   emit_count;
  logic [7:0]   b0;
  logic [7:0]   b1;
  logic [7:0]   ch;

  assign ch         = byte_data.in_byte;
  assign byte_ready = !res_valid || res_ready;
  assign accept     = byte_valid && byte_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SLASH: begin
        if (ch == CH_SLASH) state_next = ST_LINE;
        else if (ch == CH_STAR) state_next = ST_BLOCK;
        else state_next = ST_CODE;
      end
      ST_BLOCK: begin
        if (ch == CH_STAR) state_next = ST_STAR;
      end
      ST_STAR: begin
        if (ch == CH_SLASH) state_next = ST_CODE;
        else if (ch != CH_STAR) state_next = ST_BLOCK;
      end
      ST_LINE: begin
        if (ch == CH_NL) state_next = ST_CODE;
        else if (ch == CH_BSL) state_next = ST_LINE_BS;
      end
      ST_CHR: begin
        if (ch == CH_APOS) state_next = ST_CODE;
        else if (ch == CH_BSL) state_next = ST_CHR_ESC;
      end
      ST_CHR_ESC: state_next = ST_CHR;
      ST_STR: begin
        if (ch == CH_QUOTE) state_next = ST_CODE;
        else if (ch == CH_BSL) state_next = ST_STR_ESC;
      end
      ST_STR_ESC: state_next = ST_STR;
      ST_LINE_BS: begin
        if (ch != CH_BSL && ch != CH_CR) state_next = ST_LINE;
      end
      default: begin
        // plain code, and unused encodings
        if (ch == CH_SLASH) state_next = ST_SLASH;
        else if (ch == CH_APOS) state_next = ST_CHR;
        else if (ch == CH_QUOTE) state_next = ST_STR;
        else state_next = ST_CODE;
      end
    endcase
  end

  // outputs
  always_comb begin
    emit_count = EMIT_NONE;
    b0         = 8'h00;
    b1         = 8'h00;
    count_inc  = 1'b0;
    case (state)
      ST_SLASH: begin
        if (ch != CH_SLASH && ch != CH_STAR) begin
          emit_count = EMIT_TWO;
          b0         = CH_SLASH;
          b1         = ch;
        end
      end
      ST_BLOCK: ;
      ST_STAR: begin
        if (ch == CH_SLASH) count_inc = 1'b1;
      end
      ST_LINE: begin
        if (ch == CH_NL) begin
          emit_count = EMIT_ONE;
          b0         = ch;
          count_inc  = 1'b1;
        end
      end
      ST_CHR, ST_CHR_ESC, ST_STR, ST_STR_ESC: begin
        emit_count = EMIT_ONE;
        b0         = ch;
      end
      ST_LINE_BS: ;
      default: begin
        if (ch != CH_SLASH) begin
          emit_count = EMIT_ONE;
          b0         = ch;
        end
      end
    endcase
  end

  assign total_next = (count_inc && total != '1) ? total + 32'd1 : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CODE;
      total <= '0;
    end else if (accept) begin
      if (byte_data.end_of_text) begin
        state <= ST_CODE;
        total <= '0;
      end else begin
        state <= state_next;
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.emit_count       <= emit_count;
      res_data.first_byte       <= b0;
      res_data.second_byte      <= b1;
      res_data.comments_removed <= total_next;
    end
  end

  a_eot_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_data.end_of_text) |=> (state == ST_CODE && total == '0))
    else $error("parser not cleared after end of text");

  a_two_slash: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.emit_count == EMIT_TWO) |-> (res_data.first_byte == CH_SLASH))
    else $error("two-byte result without held slash");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (accept && !byte_data.end_of_text) |=> (total >= $past(total)))
    else $error("comment count went backwards");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> byte_ready)
    else $error("input stalled with empty result register");

endmodule
